// ===== rtl/core/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page free list allocator
// Word layouts of both channels, status and operation codes, register
// indexes and parameter defaults.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int ADDR_W      = 24;
	localparam int CPU_FIELD_W = 3;
	localparam int REG_W       = 13;
	localparam int CFG_INDEX_W = 2;
	// Wide enough for any page number, register value or page count.
	localparam int CMP_W       = 25;

	localparam int CPU_COUNT_DEF        = 8;
	localparam int PAGE_INDEX_BITS_DEF  = 12;
	localparam int PAGE_OFFSET_BITS_DEF = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_LOW_PAGE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_PAGE = 2'd1;

	localparam logic [REG_W-1:0] LOW_PAGE_RESET  = 13'd0;
	localparam logic [REG_W-1:0] HIGH_PAGE_RESET = 13'd4096;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OOM      = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                    operation;
		logic [CPU_FIELD_W-1:0] cpu;
		logic [ADDR_W-1:0]      address;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		status_t           status;
		logic              stolen;
	} out_word_t;

endpackage

// ===== rtl/core/per_cpu_page_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator: per-CPU LIFO free list page allocator
// Pops and pushes pages on one free list per CPU, kept as head registers
// and a next-link RAM indexed by page, with stealing from other CPUs.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              word
//   in        input       in_valid / in_stall    operation, cpu, address
//   out       output      out_valid / out_stall  page_address, status, stolen
//   cfg       input       cfg_we                 cfg_index, cfg_data
//
// After acceptance an allocate takes the next link from the RAM (S_POP) and
// finishes (S_DONE), or goes straight to S_DONE when no page is left. A free
// passes S_CHK_LO, S_CHK_HI and S_CHK_SL: the single shared comparator checks
// the low bound, the high bound and the table size in turn, then the push
// (S_PUSH) follows; a rejected free skips it. S_DONE waits while the output
// register holds an untaken word. Reset clears all lists and loads the register defaults.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator #(
	parameter int CPU_COUNT        = pfa_pkg::CPU_COUNT_DEF,
	parameter int PAGE_INDEX_BITS  = pfa_pkg::PAGE_INDEX_BITS_DEF,
	parameter int PAGE_OFFSET_BITS = pfa_pkg::PAGE_OFFSET_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  pfa_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output pfa_pkg::out_word_t                  out_data,
	input  logic                                cfg_we,
	input  logic [pfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pfa_pkg::REG_W-1:0]           cfg_data
);

	localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int PIB    = PAGE_INDEX_BITS;
	localparam int LINK_W = PAGE_INDEX_BITS + 1;
	localparam int DEPTH  = 1 << PAGE_INDEX_BITS;

	// The sequencer walks one item at a time through these steps.
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHK_LO = 7'b0000010,
		S_CHK_HI = 7'b0000100,
		S_CHK_SL = 7'b0001000,
		S_PUSH   = 7'b0010000,
		S_POP    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [pfa_pkg::REG_W-1:0] low_page_q;
	logic [pfa_pkg::REG_W-1:0] high_page_q;

	logic [PIB-1:0] list_head_q     [CPU_COUNT];
	logic           list_nonempty_q [CPU_COUNT];

	// Item context held while the sequencer runs.
	logic [pfa_pkg::ADDR_W-1:0] addr_q;
	logic [CPU_W-1:0]           cpu_idx_q;
	logic [CPU_W-1:0]           sel_q;
	logic [PIB-1:0]             page_q;
	logic                       stolen_q;
	logic                       bad_q;

	// Result waiting for the output register.
	logic [pfa_pkg::ADDR_W-1:0] res_page_q;
	pfa_pkg::status_t           res_status_q;
	logic                       res_stolen_q;

	pfa_pkg::out_word_t out_data_q;
	logic               out_valid_q;

	logic in_accept;
	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);

	// Requester and victim selection for an allocate, from the incoming word.
	logic [CPU_W-1:0] in_cpu_idx;
	logic             own_ok;
	logic             steal_found;
	logic [CPU_W-1:0] steal_sel;
	logic [CPU_W-1:0] sel_c;

	assign in_cpu_idx = CPU_W'(in_data.cpu);
	assign own_ok     = (int'(in_data.cpu) < CPU_COUNT) && list_nonempty_q[in_cpu_idx];
	assign sel_c      = own_ok ? in_cpu_idx : steal_sel;

	always_comb begin
		steal_found = 1'b0;
		steal_sel   = '0;
		// Walk from the top down so that the lowest non-empty list wins.
		for (int c = CPU_COUNT - 1; c >= 0; c--) begin
			if (list_nonempty_q[c] && (c != int'(in_data.cpu))) begin
				steal_found = 1'b1;
				steal_sel   = CPU_W'(c);
			end
		end
	end

	// Early checks of a free that need no comparator.
	logic in_bad_early;
	assign in_bad_early = (int'(in_data.cpu) >= CPU_COUNT) ||
		((in_data.address & pfa_pkg::ADDR_W'((1 << PAGE_OFFSET_BITS) - 1)) != '0);

	// Shared comparator: the page against low, high and the table size.
	logic [pfa_pkg::CMP_W-1:0] cmp_a;
	logic [pfa_pkg::CMP_W-1:0] cmp_b;
	logic                      cmp_lt;

	assign cmp_a = pfa_pkg::CMP_W'(addr_q >> PAGE_OFFSET_BITS);

	always_comb begin
		if (state_q == S_CHK_LO) begin
			cmp_b = pfa_pkg::CMP_W'(low_page_q);
		end else if (state_q == S_CHK_HI) begin
			cmp_b = pfa_pkg::CMP_W'(high_page_q);
		end else begin
			cmp_b = pfa_pkg::CMP_W'(1) << PAGE_INDEX_BITS;
		end
	end

	pfa_cmp #(
		.W(pfa_pkg::CMP_W)
	) u_cmp (
		.a (cmp_a),
		.b (cmp_b),
		.lt(cmp_lt)
	);

	// Next-link RAM: written on a push, read at the list head on an allocate.
	logic              ram_we;
	logic [PIB-1:0]    ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic              ram_re;
	logic [LINK_W-1:0] ram_rdata;

	assign ram_we    = (state_q == S_PUSH);
	assign ram_waddr = PIB'(addr_q >> PAGE_OFFSET_BITS);
	assign ram_wdata = list_nonempty_q[cpu_idx_q] ? {1'b1, list_head_q[cpu_idx_q]} : '0;
	assign ram_re    = in_accept && (in_data.operation == pfa_pkg::OP_ALLOC);

	pfa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(list_head_q[sel_c]),
		.rdata(ram_rdata)
	);

	logic [PIB+PAGE_OFFSET_BITS-1:0] page_shift;
	assign page_shift = {page_q, {PAGE_OFFSET_BITS{1'b0}}};

	// The result moves on when the output register is empty or being taken.
	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Control state: sequencer, lists, registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_page_q  <= pfa_pkg::LOW_PAGE_RESET;
			high_page_q <= pfa_pkg::HIGH_PAGE_RESET;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CPU_COUNT; c++) begin
				list_head_q[c]     <= '0;
				list_nonempty_q[c] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == pfa_pkg::REG_LOW_PAGE) begin
					low_page_q <= cfg_data;
				end else if (cfg_index == pfa_pkg::REG_HIGH_PAGE) begin
					high_page_q <= cfg_data;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (in_data.operation == pfa_pkg::OP_FREE) begin
							state_q <= S_CHK_LO;
						end else if (own_ok || steal_found) begin
							state_q <= S_POP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CHK_LO: state_q <= S_CHK_HI;
				S_CHK_HI: state_q <= S_CHK_SL;
				S_CHK_SL: begin
					state_q <= (bad_q || !cmp_lt) ? S_DONE : S_PUSH;
				end
				S_PUSH: begin
					list_head_q[cpu_idx_q]     <= ram_waddr;
					list_nonempty_q[cpu_idx_q] <= 1'b1;
					state_q                    <= S_DONE;
				end
				S_POP: begin
					list_head_q[sel_q]     <= ram_rdata[PIB-1:0];
					list_nonempty_q[sel_q] <= ram_rdata[PIB];
					state_q                <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item context and result words; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					addr_q       <= in_data.address;
					cpu_idx_q    <= in_cpu_idx;
					sel_q        <= sel_c;
					page_q       <= list_head_q[sel_c];
					stolen_q     <= !own_ok;
					bad_q        <= in_bad_early;
					res_page_q   <= '0;
					res_stolen_q <= 1'b0;
					res_status_q <= pfa_pkg::STATUS_OOM;
				end
			end
			S_CHK_LO: begin
				if (cmp_lt) begin
					bad_q <= 1'b1;
				end
			end
			S_CHK_HI: begin
				if (!cmp_lt) begin
					bad_q <= 1'b1;
				end
			end
			S_CHK_SL: begin
				res_status_q <= (bad_q || !cmp_lt) ? pfa_pkg::STATUS_BAD_FREE
					: pfa_pkg::STATUS_OK;
			end
			S_PUSH: begin
				res_status_q <= pfa_pkg::STATUS_OK;
			end
			S_POP: begin
				res_page_q   <= pfa_pkg::ADDR_W'(page_shift);
				res_stolen_q <= stolen_q;
				res_status_q <= pfa_pkg::STATUS_OK;
			end
			S_DONE: begin
				if (out_load) begin
					out_data_q.page_address <= res_page_q;
					out_data_q.status       <= res_status_q;
					out_data_q.stolen       <= res_stolen_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An allocate that finds no page reports neither an address nor a steal.
	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status == pfa_pkg::STATUS_OOM) |->
			(out_data_q.page_address == '0 && !out_data_q.stolen))
		else $error("out of memory word carries a page or a steal");

	// A stolen page is always a successful allocate.
	a_stolen_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.stolen) |-> (out_data_q.status == pfa_pkg::STATUS_OK))
		else $error("stolen flag set on a failed word");

	// The link read finishes the pop in the very next cycle.
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> (state_q == S_DONE))
		else $error("pop did not complete after link read");

	// A push leaves its list non-empty.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) |=> list_nonempty_q[$past(cpu_idx_q)])
		else $error("push left the list empty");

endmodule

// ===== rtl/core/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/pfa_cmp.sv =====
// ----------------------------------------------------------------------------
// pfa_cmp: shared magnitude comparator
// Unsigned less-than used in turn for each bound check of a free.
// ----------------------------------------------------------------------------
module pfa_cmp #(
	parameter int W = pfa_pkg::CMP_W
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         lt
);

	assign lt = (a < b);

endmodule

// ===== bench/tb_per_cpu_page_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator: self-checking bench of the allocator
// Drives allocate and free words with random gaps and back pressure. A
// scoreboard keeps its own copy of the per-CPU free lists, predicts every
// grant word in order and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_free_list_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import pfa_pkg::*;

	localparam int CPUS        = CPU_COUNT_DEF;
	localparam int PAGE_BITS   = PAGE_INDEX_BITS_DEF;
	localparam int OFFSET_BITS = PAGE_OFFSET_BITS_DEF;
	localparam int PAGES       = 1 << PAGE_BITS;

	// Indexes that map to no register. Writes to them must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_B = 2'd3;

	// The receiver stops taking words this long at two points of the run, so
	// that the output register fills and the block stalls its input.
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int CYCLE_LIMIT     = 200000;
	// This covers the busy steps of a free with room to spare.
	localparam int TAIL_CYCLES     = 10;

	// ------------------------------------------------------------------------
	// Scoreboard: a private copy of the lists, heads and link table. Every
	// accepted request is applied to it at once, since the block serves
	// requests strictly in order, and the resulting grant word is queued.
	// ------------------------------------------------------------------------
	class page_grant_board;
		logic [REG_W-1:0]     low_page;
		logic [REG_W-1:0]     high_page;
		logic [PAGE_BITS-1:0] head [CPUS];
		bit                   nonempty [CPUS];
		// The top bit says that another page follows in the same list.
		logic [PAGE_BITS:0]   link [PAGES];
		out_word_t            pending_grants [$];
		int unsigned          mismatches;

		function new();
			low_page   = LOW_PAGE_RESET;
			high_page  = HIGH_PAGE_RESET;
			mismatches = 0;
			foreach (head[c]) begin
				head[c]     = '0;
				nonempty[c] = 1'b0;
			end
			foreach (link[p])
				link[p] = '0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [REG_W-1:0] value);
			case (index)
				REG_LOW_PAGE: begin
					low_page = value;
				end
				REG_HIGH_PAGE: begin
					high_page = value;
				end
				default: begin
				end
			endcase
		endfunction

		// Takes the top page of list c and moves the head down one link.
		function logic [PAGE_BITS-1:0] pop_list(int c);
			logic [PAGE_BITS-1:0] page;
			logic [PAGE_BITS:0]   below;
			page  = head[c];
			below = link[page];
			if (below[PAGE_BITS]) begin
				head[c] = below[PAGE_BITS-1:0];
			end else begin
				head[c]     = '0;
				nonempty[c] = 1'b0;
			end
			return page;
		endfunction

		function void note_request(in_word_t w);
			out_word_t   grant;
			int unsigned page;
			bit          found;
			grant.page_address = '0;
			grant.status       = STATUS_OK;
			grant.stolen       = 1'b0;
			if (w.operation == OP_FREE) begin
				page = 32'(w.address >> OFFSET_BITS);
				if (w.cpu >= CPUS || w.address[OFFSET_BITS-1:0] != '0 ||
						page < low_page || page >= high_page || page >= PAGES) begin
					grant.status = STATUS_BAD_FREE;
				end else begin
					link[page]    = nonempty[w.cpu] ? {1'b1, head[w.cpu]} : '0;
					head[w.cpu]     = page[PAGE_BITS-1:0];
					nonempty[w.cpu] = 1'b1;
				end
			end else begin
				found = 1'b0;
				page  = 0;
				if (w.cpu < CPUS && nonempty[w.cpu]) begin
					page  = 32'(pop_list(int'(w.cpu)));
					found = 1'b1;
				end else begin
					// Steal from the lowest-numbered other CPU that has a page.
					for (int c = 0; c < CPUS; c++) begin
						if (!found && c != w.cpu && nonempty[c]) begin
							page         = 32'(pop_list(c));
							found        = 1'b1;
							grant.stolen = 1'b1;
						end
					end
				end
				if (found)
					grant.page_address = ADDR_W'(page << OFFSET_BITS);
				else
					grant.status = STATUS_OOM;
			end
			pending_grants.push_back(grant);
		endfunction

		function void check_grant(out_word_t got);
			out_word_t want;
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected grant word: page_address %h status %s stolen %b",
						got.page_address, got.status.name(), got.stolen);
				return;
			end
			want = pending_grants.pop_front();
			if (got.page_address !== want.page_address || got.status !== want.status ||
					got.stolen !== want.stolen) begin
				mismatches++;
				if (mismatches <= 10)
					$display("grant mismatch: expected %h %s %b, got %h %s %b",
						want.page_address, want.status.name(), want.stolen,
						got.page_address, got.status.name(), got.stolen);
			end
		endfunction

		function int pending();
			return pending_grants.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test. Every input has a known value from time zero.
	// ------------------------------------------------------------------------
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_word_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_word_t        out_data;
	logic             cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data  = '0;

	per_cpu_page_free_list_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	page_grant_board board;

	// Sender pacing. In a calm stretch every word follows the last one with
	// no gap; otherwise each word waits a random number of cycles first.
	bit          sender_calm = 1'b0;
	int unsigned words_sent  = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Drive tasks. Everything changes at the falling edge; handshakes are
	// judged at the rising edge from the values that held just before it.
	// ------------------------------------------------------------------------
	function automatic in_word_t req(op_t op, logic [CPU_FIELD_W-1:0] cpu,
			logic [ADDR_W-1:0] address);
		in_word_t w;
		w.operation = op;
		w.cpu       = cpu;
		w.address   = address;
		return w;
	endfunction

	// Builds one random request for the current page window. Most frees name
	// an aligned page inside the window so that lists really grow; some hit
	// the page just outside either bound, and the rest carry a raw address
	// that is almost always misaligned. Allocates carry a random address too,
	// which the block must ignore.
	function automatic in_word_t make_request(int unsigned free_pct);
		in_word_t    w;
		int unsigned lo;
		int unsigned top;
		int unsigned page;
		int unsigned pick;
		lo          = 32'(board.low_page);
		top         = (board.high_page > PAGES) ? PAGES : 32'(board.high_page);
		w.cpu       = CPU_FIELD_W'($urandom_range(0, CPUS - 1));
		w.address   = ADDR_W'($urandom);
		w.operation = OP_ALLOC;
		if ($urandom_range(0, 99) >= free_pct)
			return w;
		w.operation = OP_FREE;
		pick        = $urandom_range(0, 99);
		if (pick < 75 && lo < top)
			page = $urandom_range(lo, top - 1);
		else if (pick < 90) begin
			if (lo > 0 && (top >= PAGES || $urandom_range(0, 1) == 1))
				page = lo - 1;
			else if (top < PAGES)
				page = top;
			else
				page = $urandom_range(0, PAGES - 1);
		end else
			return w;
		w.address = ADDR_W'(page << OFFSET_BITS);
		return w;
	endfunction

	// Offers one word and returns at the falling edge after it was taken. With
	// no gap drawn, valid simply stays high into the next word.
	task automatic send_request(in_word_t w);
		int unsigned gap;
		gap = sender_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (in_stall);
		board.note_request(w);
		words_sent++;
		if (words_sent % 64 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
		@(negedge clk);
	endtask

	// Drops valid and waits until every predicted grant has come out. Since
	// every request yields exactly one grant, the block is idle after that.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [REG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(index, value);
		@(negedge clk);
	endtask

	// One random phase: new window, then a stream of requests whose mix of
	// frees and allocates decides whether the lists grow or drain.
	task automatic run_phase(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
			input int unsigned words, input int unsigned free_pct);
		write_reg(REG_UNMAPPED_A, REG_W'($urandom));
		write_reg(REG_UNMAPPED_B, REG_W'($urandom));
		write_reg(REG_HIGH_PAGE, hi);
		write_reg(REG_LOW_PAGE, lo);
		repeat (words)
			send_request(make_request(free_pct));
		settle();
	endtask

	// ------------------------------------------------------------------------
	// Receiver: takes grant words with random stalls, calm stretches, and two
	// long hold-offs while the sender keeps offering words.
	// ------------------------------------------------------------------------
	task automatic take_grants();
		int unsigned gap;
		int unsigned taken;
		bit          calm;
		taken = 0;
		calm  = 1'b0;
		forever begin
			if (taken == 300 || taken == 800)
				gap = HOLD_OFF_CYCLES;
			else
				gap = calm ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			board.check_grant(out_data);
			taken++;
			if (taken % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			@(negedge clk);
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(negedge clk);
		take_grants();
	end

	// A hung handshake ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		board = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, full window first.
		write_reg(REG_LOW_PAGE, LOW_PAGE_RESET);
		write_reg(REG_HIGH_PAGE, HIGH_PAGE_RESET);
		// Allocates with every list empty report out of memory.
		send_request(req(OP_ALLOC, 3'd0, 24'h000000));
		send_request(req(OP_ALLOC, 3'd7, 24'hFFFFFF));
		// Misaligned frees: lowest offset bit, all bits, top offset bit.
		send_request(req(OP_FREE, 3'd0, 24'h000001));
		send_request(req(OP_FREE, 3'd0, 24'hFFFFFF));
		send_request(req(OP_FREE, 3'd0, 24'h000800));
		// Lowest and highest page, then two pages on one list.
		send_request(req(OP_FREE, 3'd0, 24'h000000));
		send_request(req(OP_FREE, 3'd7, 24'hFFF000));
		send_request(req(OP_FREE, 3'd3, 24'h005000));
		send_request(req(OP_FREE, 3'd3, 24'h006000));
		// Own pop in LIFO order, then two steals from the lowest lists.
		send_request(req(OP_ALLOC, 3'd3, 24'h000000));
		send_request(req(OP_ALLOC, 3'd5, 24'h123456));
		send_request(req(OP_ALLOC, 3'd5, 24'h000000));
		// The same page freed on two CPUs sits on both lists at once.
		send_request(req(OP_FREE, 3'd2, 24'h00A000));
		send_request(req(OP_FREE, 3'd4, 24'h00A000));
		send_request(req(OP_ALLOC, 3'd2, 24'h000000));
		send_request(req(OP_ALLOC, 3'd4, 24'h000000));
		send_request(req(OP_ALLOC, 3'd4, 24'h000000));
		send_request(req(OP_ALLOC, 3'd1, 24'h000000));
		settle();

		// Narrow window: both bounds and the pages just outside them.
		write_reg(REG_LOW_PAGE, 13'd8);
		write_reg(REG_HIGH_PAGE, 13'd16);
		send_request(req(OP_FREE, 3'd1, 24'h007000));
		send_request(req(OP_FREE, 3'd1, 24'h008000));
		send_request(req(OP_FREE, 3'd1, 24'h00F000));
		send_request(req(OP_FREE, 3'd1, 24'h010000));
		send_request(req(OP_ALLOC, 3'd1, 24'h000000));
		send_request(req(OP_ALLOC, 3'd6, 24'h000000));
		settle();

		// Random phases over several windows, the extremes among them.
		run_phase(13'd0, 13'd4096, 350, 55);
		run_phase(13'd100, 13'd140, 250, 50);
		run_phase(13'd4095, 13'h1FFF, 120, 50);
		// An empty window refuses every free and drains the lists.
		run_phase(13'd0, 13'd0, 100, 30);
		run_phase(13'h1FFF, 13'h1FFF, 60, 50);
		run_phase(13'd2000, 13'd3000, 250, 45);
		run_phase(13'd0, 13'd4096, 100, 20);

		// Any stray word after the last grant is caught in this window.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/pfa_cmp.sv
rtl/core/per_cpu_page_free_list_allocator.sv
bench/tb_per_cpu_page_free_list_allocator.sv
